FILE: rtl/sialu_pkg.sv
// Package for the signed integer ALU with divide and remainder.
// Holds word types, operation and status codes, and the per-stage control struct.
// Depends on nothing; every other rtl file imports it.
package sialu_pkg;

    // Default datapath width
    localparam int DATA_WIDTH_DEF = 32;

    // Operation codes carried in the kind field
    typedef enum logic [2:0] {
        KIND_ADD = 3'd0,
        KIND_SUB = 3'd1,
        KIND_DIV = 3'd2,
        KIND_MUL = 3'd3,
        KIND_REM = 3'd4
    } kind_t;

    // Result status codes
    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_DIV_ZERO = 2'd1,
        STATUS_REM_ZERO = 2'd2
    } status_t;

    // Input word
    typedef struct packed {
        logic signed [31:0] operand_a;
        logic signed [31:0] operand_b;
        logic        [2:0]  kind;
    } in_word_t;

    // Result word
    typedef struct packed {
        logic signed [31:0] value;
        logic        [1:0]  status;
    } out_word_t;

    // Control that rides along the cell chain with each word
    typedef struct packed {
        kind_t   op;
        logic    negate;
        status_t status;
    } ctrl_t;

endpackage

FILE: rtl/sialu_prep.sv
// Front stage of the signed ALU: fits operands to the datapath width and
// loads the initial cell state (add/sub result, multiplier or divider seed).
// Depends on sialu_pkg.
module sialu_prep
    import sialu_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  logic                  in_valid,
    input  in_word_t              in_word,
    output logic                  out_valid,
    output logic [DATA_WIDTH-1:0] out_acc,
    output logic [DATA_WIDTH-1:0] out_work,
    output logic [DATA_WIDTH-1:0] out_opnd,
    output ctrl_t                 out_ctrl
);

    logic [63:0]           a_ext;
    logic [63:0]           b_ext;
    logic [DATA_WIDTH-1:0] a_w;
    logic [DATA_WIDTH-1:0] b_w;
    logic                  a_neg;
    logic                  b_neg;
    logic [DATA_WIDTH-1:0] a_mag;
    logic [DATA_WIDTH-1:0] b_mag;
    logic                  b_zero;

    logic                  valid_reg;
    logic [DATA_WIDTH-1:0] acc_reg;
    logic [DATA_WIDTH-1:0] work_reg;
    logic [DATA_WIDTH-1:0] opnd_reg;
    ctrl_t                 ctrl_reg;

    logic [DATA_WIDTH-1:0] acc_next;
    logic [DATA_WIDTH-1:0] work_next;
    logic [DATA_WIDTH-1:0] opnd_next;
    ctrl_t                 ctrl_next;

    // Sign-extend to 64 bits, then keep the datapath width
    assign a_ext  = 64'(in_word.operand_a);
    assign b_ext  = 64'(in_word.operand_b);
    assign a_w    = a_ext[DATA_WIDTH-1:0];
    assign b_w    = b_ext[DATA_WIDTH-1:0];
    assign a_neg  = a_w[DATA_WIDTH-1];
    assign b_neg  = b_w[DATA_WIDTH-1];
    assign a_mag  = a_neg ? (~a_w + DATA_WIDTH'(1)) : a_w;
    assign b_mag  = b_neg ? (~b_w + DATA_WIDTH'(1)) : b_w;
    assign b_zero = (b_w == '0);

    // Seed the chain per operation
    always_comb begin
        acc_next         = '0;
        work_next        = '0;
        opnd_next        = '0;
        ctrl_next.op     = KIND_ADD;
        ctrl_next.negate = 1'b0;
        ctrl_next.status = STATUS_OK;
        case (in_word.kind)
            KIND_ADD: begin
                acc_next = a_w + b_w;
            end
            KIND_SUB: begin
                ctrl_next.op = KIND_SUB;
                acc_next     = a_w - b_w;
            end
            KIND_MUL: begin
                ctrl_next.op = KIND_MUL;
                work_next    = b_w;
                opnd_next    = a_w;
            end
            KIND_DIV: begin
                ctrl_next.op     = KIND_DIV;
                work_next        = a_mag;
                opnd_next        = b_mag;
                ctrl_next.negate = a_neg ^ b_neg;
                ctrl_next.status = b_zero ? STATUS_DIV_ZERO : STATUS_OK;
            end
            KIND_REM: begin
                ctrl_next.op     = KIND_REM;
                work_next        = a_mag;
                opnd_next        = b_mag;
                ctrl_next.negate = a_neg;
                ctrl_next.status = b_zero ? STATUS_REM_ZERO : STATUS_OK;
            end
            default: begin
                // unknown kinds give zero with ok status
                acc_next = '0;
            end
        endcase
    end

    // Hold stage control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    // Advance stage payload
    always_ff @(posedge aclk) begin
        if (en) begin
            acc_reg  <= acc_next;
            work_reg <= work_next;
            opnd_reg <= opnd_next;
            ctrl_reg <= ctrl_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_acc   = acc_reg;
    assign out_work  = work_reg;
    assign out_opnd  = opnd_reg;
    assign out_ctrl  = ctrl_reg;

endmodule

FILE: rtl/sialu_cell.sv
// One cell of the signed ALU chain: a restoring divide step or a
// shift-and-add multiply step, registered, handed to the next cell.
// Depends on sialu_pkg.
module sialu_cell
    import sialu_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic [DATA_WIDTH-1:0] in_acc,
    input  logic [DATA_WIDTH-1:0] in_work,
    input  logic [DATA_WIDTH-1:0] in_opnd,
    input  ctrl_t                 in_ctrl,
    output logic                  out_valid,
    output logic [DATA_WIDTH-1:0] out_acc,
    output logic [DATA_WIDTH-1:0] out_work,
    output logic [DATA_WIDTH-1:0] out_opnd,
    output ctrl_t                 out_ctrl
);

    logic [DATA_WIDTH:0]   trial;
    logic [DATA_WIDTH:0]   diff;
    logic                  fits;

    logic                  valid_reg;
    logic [DATA_WIDTH-1:0] acc_reg;
    logic [DATA_WIDTH-1:0] work_reg;
    logic [DATA_WIDTH-1:0] opnd_reg;
    ctrl_t                 ctrl_reg;

    logic [DATA_WIDTH-1:0] acc_next;
    logic [DATA_WIDTH-1:0] work_next;
    logic [DATA_WIDTH-1:0] opnd_next;

    // Shift the next dividend bit into the partial remainder and trial-subtract
    assign trial = {in_acc, in_work[DATA_WIDTH-1]};
    assign diff  = trial - {1'b0, in_opnd};
    assign fits  = (trial >= {1'b0, in_opnd});

    always_comb begin
        if (in_ctrl.op == KIND_DIV || in_ctrl.op == KIND_REM) begin
            // divide: remainder in acc, quotient bits shift into work
            acc_next  = fits ? diff[DATA_WIDTH-1:0] : trial[DATA_WIDTH-1:0];
            work_next = {in_work[DATA_WIDTH-2:0], fits};
            opnd_next = in_opnd;
        end else begin
            // multiply: add shifted multiplicand on each multiplier bit
            acc_next  = in_work[0] ? (in_acc + in_opnd) : in_acc;
            work_next = in_work >> 1;
            opnd_next = in_opnd << 1;
        end
    end

    // Hold cell control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    // Advance cell payload
    always_ff @(posedge aclk) begin
        if (en) begin
            acc_reg  <= acc_next;
            work_reg <= work_next;
            opnd_reg <= opnd_next;
            ctrl_reg <= in_ctrl;
        end
    end

    assign out_valid = valid_reg;
    assign out_acc   = acc_reg;
    assign out_work  = work_reg;
    assign out_opnd  = opnd_reg;
    assign out_ctrl  = ctrl_reg;

endmodule

FILE: rtl/signed_int_alu_div_mod.sv
// Signed integer ALU: add, subtract, multiply, divide and remainder.
// Registers from acceptance to m_valid: front stage, DATA_WIDTH chain cells,
// output register; one word per cycle while the skid stage stays empty.
// The chain of DATA_WIDTH cells, one divide or multiply bit each, sets latency.
// A skid stage after the output register keeps s_ready registered.
// Synchronous active-low reset empties the chain and both output stages.
module signed_int_alu_div_mod
    import sialu_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_word_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_data
);

    logic                  en;
    logic                  valid_s [0:DATA_WIDTH];
    logic [DATA_WIDTH-1:0] acc_s   [0:DATA_WIDTH];
    logic [DATA_WIDTH-1:0] work_s  [0:DATA_WIDTH];
    logic [DATA_WIDTH-1:0] opnd_s  [0:DATA_WIDTH];
    ctrl_t                 ctrl_s  [0:DATA_WIDTH];

    logic [DATA_WIDTH-1:0]        sel_val;
    logic [DATA_WIDTH-1:0]        signed_val;
    logic signed [DATA_WIDTH-1:0] res_s;
    logic [63:0]                  res_ext;
    out_word_t                    result;
    logic                         last_valid;

    logic      m_valid_reg;
    out_word_t m_data_reg;
    logic      skid_valid_reg;
    out_word_t skid_data_reg;

    // Chain advances whenever the skid stage is free
    assign en      = !skid_valid_reg;
    assign s_ready = en;

    sialu_prep #(
        .DATA_WIDTH(DATA_WIDTH)
    ) u_prep (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_valid),
        .in_word   (s_data),
        .out_valid (valid_s[0]),
        .out_acc   (acc_s[0]),
        .out_work  (work_s[0]),
        .out_opnd  (opnd_s[0]),
        .out_ctrl  (ctrl_s[0])
    );

    for (genvar i = 0; i < DATA_WIDTH; i++) begin : g_cell
        sialu_cell #(
            .DATA_WIDTH(DATA_WIDTH)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (valid_s[i]),
            .in_acc    (acc_s[i]),
            .in_work   (work_s[i]),
            .in_opnd   (opnd_s[i]),
            .in_ctrl   (ctrl_s[i]),
            .out_valid (valid_s[i+1]),
            .out_acc   (acc_s[i+1]),
            .out_work  (work_s[i+1]),
            .out_opnd  (opnd_s[i+1]),
            .out_ctrl  (ctrl_s[i+1])
        );
    end

    // Pick quotient, remainder or accumulator and apply the sign
    always_comb begin
        case (ctrl_s[DATA_WIDTH].op)
            KIND_DIV: sel_val = work_s[DATA_WIDTH];
            default:  sel_val = acc_s[DATA_WIDTH];
        endcase
    end

    assign signed_val = ctrl_s[DATA_WIDTH].negate ? (~sel_val + DATA_WIDTH'(1)) : sel_val;
    assign res_s      = (ctrl_s[DATA_WIDTH].status == STATUS_OK) ? signed_val : '0;
    assign res_ext    = 64'(res_s);

    assign result.value  = res_ext[31:0];
    assign result.status = ctrl_s[DATA_WIDTH].status;
    assign last_valid    = en && valid_s[DATA_WIDTH];

    // Hold output and skid control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (m_valid_reg && !m_ready) begin
            if (last_valid) begin
                skid_valid_reg <= 1'b1;
            end
        end else if (skid_valid_reg) begin
            m_valid_reg    <= 1'b1;
            skid_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= last_valid;
        end
    end

    // Advance output and skid words
    always_ff @(posedge aclk) begin
        if (m_valid_reg && !m_ready) begin
            if (last_valid) begin
                skid_data_reg <= result;
            end
        end else if (skid_valid_reg) begin
            m_data_reg <= skid_data_reg;
        end else begin
            m_data_reg <= result;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
